// File: design/ole_pkg.sv
package ole_pkg;

    // Default list depth
    localparam int CAPACITY_DEF = 16;

    // Field widths
    localparam int OP_W  = 3;
    localparam int VAL_W = 32;
    localparam int ST_W  = 2;
    localparam int POS_W = 5;

    typedef logic [POS_W-1:0] t_pos;

    // Operation codes
    localparam logic [OP_W-1:0] OP_FRONT  = 3'd0;
    localparam logic [OP_W-1:0] OP_BACK   = 3'd1;
    localparam logic [OP_W-1:0] OP_SORT   = 3'd2;
    localparam logic [OP_W-1:0] OP_REMOVE = 3'd3;
    localparam logic [OP_W-1:0] OP_SEARCH = 3'd4;

    // Status codes
    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL      = 2'd1;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd2;

    // Jump conditions
    typedef enum logic [2:0] {
        CD_NONE,
        CD_FULL,
        CD_PEND,
        CD_P1END,
        CD_JLEP,
        CD_EQ,
        CD_NOT_GT
    } t_cond;

    // Position pointer update
    typedef enum logic [1:0] {
        PO_HOLD,
        PO_CNT,
        PO_INC
    } t_pop;

    // Shift pointer update
    typedef enum logic {
        JO_HOLD,
        JO_DEC
    } t_jop;

    // Memory read address select
    typedef enum logic [1:0] {
        RA_P,
        RA_JM1,
        RA_P1
    } t_rsel;

    // Memory write select
    typedef enum logic [1:0] {
        WR_NONE,
        WR_J_RD,
        WR_P_RD,
        WR_P_VAL
    } t_wsel;

    // Count update
    typedef enum logic [1:0] {
        CN_HOLD,
        CN_INC,
        CN_DEC
    } t_cnop;

    // Finish codes
    typedef enum logic [2:0] {
        FN_NONE,
        FN_OK,
        FN_FULL,
        FN_NF,
        FN_FOUND
    } t_fin;

    // Microprogram steps
    typedef enum logic [4:0] {
        S_NOP,
        S_FRONT,
        S_BACK,
        S_SORT,
        S_SSCAN,
        S_SCMP,
        S_SHIFT,
        S_SHRD,
        S_PUT,
        S_FULL,
        S_RSCAN,
        S_RCMP,
        S_CLOSE,
        S_CLRD,
        S_DEC,
        S_QSCAN,
        S_QCMP,
        S_FOUND,
        S_NF
    } t_step;

    // One control word of the microprogram
    typedef struct packed {
        t_cond cond;
        logic  guard;
        t_step t_true;
        t_step t_false;
        t_pop  p_op;
        t_jop  j_op;
        logic  rd_en;
        t_rsel rsel;
        t_wsel wsel;
        t_cnop cn_op;
        t_fin  fin;
    } t_uword;

    // Datapath controls for the current cycle
    typedef struct packed {
        logic  load;
        t_pop  p_op;
        t_jop  j_op;
        logic  rd_en;
        t_rsel rsel;
        t_wsel wsel;
        t_cnop cn_op;
        t_fin  fin;
    } t_ctl;

    // Datapath status for jump conditions
    typedef struct packed {
        logic full;
        logic pend;
        logic p1end;
        logic jlep;
        logic eq;
        logic gt;
    } t_flags;

    // Result fields
    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [POS_W-1:0] position;
        logic [POS_W-1:0] entry_count;
    } t_result;

endpackage

// File: design/ole_if.sv
interface ole_req_if;
    logic                            valid;
    logic                            ready;
    logic [ole_pkg::OP_W-1:0]        operation;
    logic signed [ole_pkg::VAL_W-1:0] value;

    modport source (output valid, output operation, output value, input ready);
    modport sink (input valid, input operation, input value, output ready);
endinterface

interface ole_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [ole_pkg::ST_W-1:0]    status;
    logic [ole_pkg::POS_W-1:0]   position;
    logic [ole_pkg::POS_W-1:0]   entry_count;

    modport source (output valid, output status, output position, output entry_count,
                    input ready);
    modport sink (input valid, input status, input position, input entry_count,
                  output ready);
endinterface

// File: design/ordered_list_engine.sv
// Ordered list engine: a bounded list of signed 32-bit values.
// i_req carries one request (operation, value); it is taken on a cycle with
// valid and ready high. o_rsp returns one response per request: status,
// 1-based search position and the entry count after the operation.
// Operations: insert at front, insert at back, ascending sorted insert,
// remove first equal entry, search. Other operation codes leave the list as is.
// A microprogram walks the list through a storage array with separate read
// and write addresses, two steps per entry visited (read, then compare or
// move). i_req.ready is high whenever no request is in progress, so the next
// request is taken the cycle after a response is loaded, even while that
// response still waits.
// A finished request holds in its last step while the output register is
// full and o_rsp.ready is low.
// Reset empties the list and drops any pending response; entry contents are
// not cleared since only entries below the count are ever read.
module ordered_list_engine #(
    parameter int CAPACITY = ole_pkg::CAPACITY_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ole_req_if.sink    i_req,
    ole_rsp_if.source  o_rsp
);

    ole_pkg::t_ctl    w_ctl;
    ole_pkg::t_flags  w_flags;
    ole_pkg::t_result w_result;
    logic             w_busy;
    logic             w_start;
    logic             w_out_free;
    logic             w_res_load;

    logic                        r_valid;
    logic [ole_pkg::ST_W-1:0]    r_status;
    logic [ole_pkg::POS_W-1:0]   r_position;
    logic [ole_pkg::POS_W-1:0]   r_entry_count;

    assign i_req.ready = !w_busy;
    assign w_start     = i_req.valid && !w_busy;
    assign w_out_free  = !r_valid || o_rsp.ready;
    assign w_res_load  = (w_ctl.fin != ole_pkg::FN_NONE);

    ole_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_op       (i_req.operation),
        .i_out_free (w_out_free),
        .i_flags    (w_flags),
        .o_busy     (w_busy),
        .o_ctl      (w_ctl)
    );

    ole_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl),
        .i_value  (i_req.value),
        .o_flags  (w_flags),
        .o_result (w_result)
    );

    // Output register: load on finish, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_res_load) begin
            r_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_load) begin
            r_status      <= w_result.status;
            r_position    <= w_result.position;
            r_entry_count <= w_result.entry_count;
        end
    end

    assign o_rsp.valid       = r_valid;
    assign o_rsp.status      = r_status;
    assign o_rsp.position    = r_position;
    assign o_rsp.entry_count = r_entry_count;

    // A full report always comes with a full list
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.status == ole_pkg::ST_FULL
        |-> o_rsp.entry_count == ole_pkg::t_pos'(CAPACITY))
        else $error("full status with list not full");

    // Only a successful search reports a position
    a_pos_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.position != '0 |-> o_rsp.status == ole_pkg::ST_OK)
        else $error("position reported with non-ok status");

    // An accepted request closes the input until it finishes
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.valid && i_req.ready |=> !i_req.ready)
        else $error("input ready right after accept");

    // A response never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_load |-> (!r_valid || o_rsp.ready))
        else $error("response overwritten");

endmodule

// File: design/ole_ctrl.sv
module ole_ctrl (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [ole_pkg::OP_W-1:0] i_op,
    input  logic                     i_out_free,
    input  ole_pkg::t_flags          i_flags,
    output logic                     o_busy,
    output ole_pkg::t_ctl            o_ctl
);

    // Microprogram ROM
    function automatic ole_pkg::t_uword rom(input ole_pkg::t_step s);
        ole_pkg::t_uword w;
        w = '{cond: ole_pkg::CD_NONE, guard: 1'b0,
              t_true: ole_pkg::S_NOP, t_false: ole_pkg::S_NOP,
              p_op: ole_pkg::PO_HOLD, j_op: ole_pkg::JO_HOLD,
              rd_en: 1'b0, rsel: ole_pkg::RA_P, wsel: ole_pkg::WR_NONE,
              cn_op: ole_pkg::CN_HOLD, fin: ole_pkg::FN_NONE};
        case (s)
            ole_pkg::S_NOP: begin
                w.fin = ole_pkg::FN_OK;
            end
            ole_pkg::S_FRONT: begin
                w.cond    = ole_pkg::CD_FULL;
                w.t_true  = ole_pkg::S_FULL;
                w.t_false = ole_pkg::S_SHIFT;
            end
            ole_pkg::S_BACK: begin
                w.cond    = ole_pkg::CD_FULL;
                w.t_true  = ole_pkg::S_FULL;
                w.t_false = ole_pkg::S_SHIFT;
                w.p_op    = ole_pkg::PO_CNT;
            end
            ole_pkg::S_SORT: begin
                w.cond    = ole_pkg::CD_FULL;
                w.t_true  = ole_pkg::S_FULL;
                w.t_false = ole_pkg::S_SSCAN;
            end
            ole_pkg::S_SSCAN: begin
                w.cond    = ole_pkg::CD_PEND;
                w.guard   = 1'b1;
                w.t_true  = ole_pkg::S_SHIFT;
                w.t_false = ole_pkg::S_SCMP;
                w.rd_en   = 1'b1;
                w.rsel    = ole_pkg::RA_P;
            end
            ole_pkg::S_SCMP: begin
                w.cond    = ole_pkg::CD_NOT_GT;
                w.guard   = 1'b1;
                w.t_true  = ole_pkg::S_SHIFT;
                w.t_false = ole_pkg::S_SSCAN;
                w.p_op    = ole_pkg::PO_INC;
            end
            ole_pkg::S_SHIFT: begin
                w.cond    = ole_pkg::CD_JLEP;
                w.guard   = 1'b1;
                w.t_true  = ole_pkg::S_PUT;
                w.t_false = ole_pkg::S_SHRD;
                w.rd_en   = 1'b1;
                w.rsel    = ole_pkg::RA_JM1;
            end
            ole_pkg::S_SHRD: begin
                w.t_false = ole_pkg::S_SHIFT;
                w.wsel    = ole_pkg::WR_J_RD;
                w.j_op    = ole_pkg::JO_DEC;
            end
            ole_pkg::S_PUT: begin
                w.wsel  = ole_pkg::WR_P_VAL;
                w.cn_op = ole_pkg::CN_INC;
                w.fin   = ole_pkg::FN_OK;
            end
            ole_pkg::S_FULL: begin
                w.fin = ole_pkg::FN_FULL;
            end
            ole_pkg::S_RSCAN: begin
                w.cond    = ole_pkg::CD_PEND;
                w.guard   = 1'b1;
                w.t_true  = ole_pkg::S_NF;
                w.t_false = ole_pkg::S_RCMP;
                w.rd_en   = 1'b1;
                w.rsel    = ole_pkg::RA_P;
            end
            ole_pkg::S_RCMP: begin
                w.cond    = ole_pkg::CD_EQ;
                w.guard   = 1'b1;
                w.t_true  = ole_pkg::S_CLOSE;
                w.t_false = ole_pkg::S_RSCAN;
                w.p_op    = ole_pkg::PO_INC;
            end
            ole_pkg::S_CLOSE: begin
                w.cond    = ole_pkg::CD_P1END;
                w.guard   = 1'b1;
                w.t_true  = ole_pkg::S_DEC;
                w.t_false = ole_pkg::S_CLRD;
                w.rd_en   = 1'b1;
                w.rsel    = ole_pkg::RA_P1;
            end
            ole_pkg::S_CLRD: begin
                w.t_false = ole_pkg::S_CLOSE;
                w.wsel    = ole_pkg::WR_P_RD;
                w.p_op    = ole_pkg::PO_INC;
            end
            ole_pkg::S_DEC: begin
                w.cn_op = ole_pkg::CN_DEC;
                w.fin   = ole_pkg::FN_OK;
            end
            ole_pkg::S_QSCAN: begin
                w.cond    = ole_pkg::CD_PEND;
                w.guard   = 1'b1;
                w.t_true  = ole_pkg::S_NF;
                w.t_false = ole_pkg::S_QCMP;
                w.rd_en   = 1'b1;
                w.rsel    = ole_pkg::RA_P;
            end
            ole_pkg::S_QCMP: begin
                w.cond    = ole_pkg::CD_EQ;
                w.guard   = 1'b1;
                w.t_true  = ole_pkg::S_FOUND;
                w.t_false = ole_pkg::S_QSCAN;
                w.p_op    = ole_pkg::PO_INC;
            end
            ole_pkg::S_FOUND: begin
                w.fin = ole_pkg::FN_FOUND;
            end
            ole_pkg::S_NF: begin
                w.fin = ole_pkg::FN_NF;
            end
            default: begin
                w.fin = ole_pkg::FN_OK;
            end
        endcase
        return w;
    endfunction

    ole_pkg::t_step  r_pc, n_pc;
    logic            r_busy, n_busy;
    ole_pkg::t_uword w_uw;
    logic            w_cond;
    logic            w_exec;
    logic            w_apply;

    // Fetch the control word and pick its jump condition
    always_comb begin
        w_uw = rom(r_pc);
        case (w_uw.cond)
            ole_pkg::CD_NONE:   w_cond = 1'b0;
            ole_pkg::CD_FULL:   w_cond = i_flags.full;
            ole_pkg::CD_PEND:   w_cond = i_flags.pend;
            ole_pkg::CD_P1END:  w_cond = i_flags.p1end;
            ole_pkg::CD_JLEP:   w_cond = i_flags.jlep;
            ole_pkg::CD_EQ:     w_cond = i_flags.eq;
            ole_pkg::CD_NOT_GT: w_cond = !i_flags.gt;
            default:            w_cond = 1'b0;
        endcase
    end

    // Hold a finishing step until the output register can take the response
    assign w_exec  = r_busy && ((w_uw.fin == ole_pkg::FN_NONE) || i_out_free);
    assign w_apply = w_exec && !(w_uw.guard && w_cond);

    // Drive the datapath
    always_comb begin
        o_ctl.load  = i_start;
        o_ctl.p_op  = w_apply ? w_uw.p_op : ole_pkg::PO_HOLD;
        o_ctl.j_op  = w_apply ? w_uw.j_op : ole_pkg::JO_HOLD;
        o_ctl.rd_en = w_apply && w_uw.rd_en;
        o_ctl.rsel  = w_uw.rsel;
        o_ctl.wsel  = w_apply ? w_uw.wsel : ole_pkg::WR_NONE;
        o_ctl.cn_op = w_apply ? w_uw.cn_op : ole_pkg::CN_HOLD;
        o_ctl.fin   = w_exec ? w_uw.fin : ole_pkg::FN_NONE;
    end

    // Dispatch on the operation, then advance the step counter
    always_comb begin
        n_pc   = r_pc;
        n_busy = r_busy;
        if (!r_busy) begin
            if (i_start) begin
                n_busy = 1'b1;
                case (i_op)
                    ole_pkg::OP_FRONT:  n_pc = ole_pkg::S_FRONT;
                    ole_pkg::OP_BACK:   n_pc = ole_pkg::S_BACK;
                    ole_pkg::OP_SORT:   n_pc = ole_pkg::S_SORT;
                    ole_pkg::OP_REMOVE: n_pc = ole_pkg::S_RSCAN;
                    ole_pkg::OP_SEARCH: n_pc = ole_pkg::S_QSCAN;
                    default:            n_pc = ole_pkg::S_NOP;
                endcase
            end
        end else if (w_exec) begin
            n_pc = w_cond ? w_uw.t_true : w_uw.t_false;
            if (w_uw.fin != ole_pkg::FN_NONE) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pc   <= ole_pkg::S_NOP;
        end else begin
            r_busy <= n_busy;
            r_pc   <= n_pc;
        end
    end

    assign o_busy = r_busy;

endmodule

// File: design/ole_dpath.sv
module ole_dpath #(
    parameter int CAPACITY = ole_pkg::CAPACITY_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  ole_pkg::t_ctl                    i_ctl,
    input  logic signed [ole_pkg::VAL_W-1:0] i_value,
    output ole_pkg::t_flags                  o_flags,
    output ole_pkg::t_result                 o_result
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);

    logic signed [ole_pkg::VAL_W-1:0] r_mem [CAPACITY];
    logic signed [ole_pkg::VAL_W-1:0] r_val;
    logic signed [ole_pkg::VAL_W-1:0] r_rd;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [CW-1:0] r_p, n_p;
    logic [CW-1:0] r_j, n_j;
    logic [CW-1:0] w_p1, w_jm1;
    logic [AW-1:0] w_raddr, w_waddr;
    logic signed [ole_pkg::VAL_W-1:0] w_wdata;
    logic          w_wen;

    assign w_p1  = r_p + CW'(1);
    assign w_jm1 = r_j - CW'(1);

    // Pointer and count updates
    always_comb begin
        case (i_ctl.p_op)
            ole_pkg::PO_CNT: n_p = r_cnt;
            ole_pkg::PO_INC: n_p = w_p1;
            default:         n_p = r_p;
        endcase
        if (i_ctl.load) begin
            n_p = '0;
        end

        n_j = (i_ctl.j_op == ole_pkg::JO_DEC) ? w_jm1 : r_j;
        if (i_ctl.load) begin
            n_j = r_cnt;
        end

        case (i_ctl.cn_op)
            ole_pkg::CN_INC: n_cnt = r_cnt + CW'(1);
            ole_pkg::CN_DEC: n_cnt = r_cnt - CW'(1);
            default:         n_cnt = r_cnt;
        endcase
    end

    // Memory address and data selection
    always_comb begin
        case (i_ctl.rsel)
            ole_pkg::RA_JM1: w_raddr = w_jm1[AW-1:0];
            ole_pkg::RA_P1:  w_raddr = w_p1[AW-1:0];
            default:         w_raddr = r_p[AW-1:0];
        endcase
        w_wen   = 1'b1;
        w_waddr = r_p[AW-1:0];
        w_wdata = r_rd;
        case (i_ctl.wsel)
            ole_pkg::WR_J_RD:  w_waddr = r_j[AW-1:0];
            ole_pkg::WR_P_RD:  w_waddr = r_p[AW-1:0];
            ole_pkg::WR_P_VAL: w_wdata = r_val;
            default:           w_wen   = 1'b0;
        endcase
    end

    // List storage with registered read data
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rd <= r_mem[w_raddr];
        end
        if (w_wen) begin
            r_mem[w_waddr] <= w_wdata;
        end
    end

    // Request value and pointers
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_val <= i_value;
        end
        r_p <= n_p;
        r_j <= n_j;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    // Flags for the sequencer
    always_comb begin
        o_flags.full  = (r_cnt >= CW'(CAPACITY));
        o_flags.pend  = (r_p >= r_cnt);
        o_flags.p1end = (w_p1 >= r_cnt);
        o_flags.jlep  = (r_j <= r_p);
        o_flags.eq    = (r_rd == r_val);
        o_flags.gt    = (r_val > r_rd);
    end

    // Result fields for the finishing step
    always_comb begin
        case (i_ctl.fin)
            ole_pkg::FN_FULL: o_result.status = ole_pkg::ST_FULL;
            ole_pkg::FN_NF:   o_result.status = ole_pkg::ST_NOT_FOUND;
            default:          o_result.status = ole_pkg::ST_OK;
        endcase
        o_result.position    = (i_ctl.fin == ole_pkg::FN_FOUND) ?
                               ole_pkg::t_pos'(w_p1) : '0;
        o_result.entry_count = ole_pkg::t_pos'(n_cnt);
    end

endmodule

// File: sim/ordered_list_engine_tb.sv
`timescale 1ns / 100ps

module ordered_list_engine_tb;

    localparam int CAP           = ole_pkg::CAPACITY_DEF;
    localparam int RANDOM_ITEMS  = 450;
    localparam int IDLE_LIMIT    = 2000;
    localparam int DRAIN_CYCLES  = 2 * CAP + 16;

    // Operation code that the block has no use for
    localparam logic [ole_pkg::OP_W-1:0] OP_RESERVED = 3'd7;

    localparam logic signed [ole_pkg::VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [ole_pkg::VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;

    // Mirror of the list contents and the queue of responses still owed
    class list_scoreboard;
        logic signed [ole_pkg::VAL_W-1:0] slots[CAP];
        int                               used;
        ole_pkg::t_result                 owed[$];
        int                               fails;

        function new();
            used  = 0;
            fails = 0;
        endfunction

        // Index of the first equal entry, or -1
        function int find_equal(logic signed [ole_pkg::VAL_W-1:0] val);
            for (int k = 0; k < used; k++)
                if (slots[k] == val)
                    return k;
            return -1;
        endfunction

        function logic signed [ole_pkg::VAL_W-1:0] pick_entry();
            return slots[$urandom_range(0, used - 1)];
        endfunction

        // Apply one accepted request to the mirror and queue its response
        function void note_request(logic [ole_pkg::OP_W-1:0] op,
                                   logic signed [ole_pkg::VAL_W-1:0] val);
            ole_pkg::t_result r;
            int               k;
            r.status   = ole_pkg::ST_OK;
            r.position = '0;
            case (op)
                ole_pkg::OP_FRONT, ole_pkg::OP_BACK, ole_pkg::OP_SORT: begin
                    if (used >= CAP) begin
                        r.status = ole_pkg::ST_FULL;
                    end else begin
                        if (op == ole_pkg::OP_FRONT) begin
                            k = 0;
                        end else if (op == ole_pkg::OP_BACK) begin
                            k = used;
                        end else begin
                            k = 0;
                            while (k < used && val > slots[k])
                                k++;
                        end
                        for (int j = used; j > k; j--)
                            slots[j] = slots[j-1];
                        slots[k] = val;
                        used++;
                    end
                end
                ole_pkg::OP_REMOVE: begin
                    k = find_equal(val);
                    if (k < 0) begin
                        r.status = ole_pkg::ST_NOT_FOUND;
                    end else begin
                        for (int j = k; j + 1 < used; j++)
                            slots[j] = slots[j+1];
                        used--;
                    end
                end
                ole_pkg::OP_SEARCH: begin
                    k = find_equal(val);
                    if (k < 0)
                        r.status = ole_pkg::ST_NOT_FOUND;
                    else
                        r.position = ole_pkg::t_pos'(k + 1);
                end
                default: ;
            endcase
            r.entry_count = ole_pkg::t_pos'(used);
            owed.push_back(r);
        endfunction

        task report(string msg);
            $display("%0t ERROR: %s", $time, msg);
            fails++;
        endtask

        // Compare one accepted response with the oldest one owed
        task check_response(ole_pkg::t_result got);
            ole_pkg::t_result want;
            if (owed.size() == 0) begin
                report("response with no request outstanding");
            end else begin
                want = owed.pop_front();
                if (got.status !== want.status)
                    report($sformatf("status %0d, expected %0d", got.status, want.status));
                if (got.position !== want.position)
                    report($sformatf("position %0d, expected %0d",
                                     got.position, want.position));
                if (got.entry_count !== want.entry_count)
                    report($sformatf("entry_count %0d, expected %0d",
                                     got.entry_count, want.entry_count));
            end
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    ole_req_if req();
    ole_rsp_if rsp();

    list_scoreboard sb;
    int             burst_left;

    ordered_list_engine dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_rsp   (rsp)
    );

    // Free-running clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // End a burst with a gap, or keep the request valid for the next one
    task automatic pace();
        burst_left--;
        if (burst_left <= 0) begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: burst_left = $urandom_range(1, 4);
                5, 6, 7:       burst_left = $urandom_range(5, 20);
                default:       burst_left = $urandom_range(20, 60);
            endcase
        end
    endtask

    // Present one request and hold it until accepted
    task automatic send_request(input logic [ole_pkg::OP_W-1:0] op,
                                input logic signed [ole_pkg::VAL_W-1:0] val);
        req.valid     <= 1'b1;
        req.operation <= op;
        req.value     <= val;
        @(posedge i_clk);
        while (!req.ready)
            @(posedge i_clk);
        sb.note_request(op, val);
        pace();
    endtask

    // Request value: half the time from a small range so duplicates and hits are common
    function automatic logic signed [ole_pkg::VAL_W-1:0] pick_value();
        logic signed [ole_pkg::VAL_W-1:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
                v = $urandom_range(0, 16);
                v = v - 8;
            end
            5: v = VAL_MIN;
            6: v = VAL_MAX;
            default: v = $urandom();
        endcase
        return v;
    endfunction

    // Stimulus: directed corner cases, then random fill and drain phases
    initial begin
        logic [ole_pkg::OP_W-1:0]         op;
        logic signed [ole_pkg::VAL_W-1:0] val;
        bit                               filling;
        int                               phase_left;
        int                               pick;

        sb            = new();
        i_rst_n       = 1'b0;
        req.valid     = 1'b0;
        req.operation = ole_pkg::OP_FRONT;
        req.value     = '0;
        burst_left    = 3;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty list, reserved code, sorted inserts at head, tail and middle, then front, back, search and remove
        send_request(ole_pkg::OP_SEARCH, VAL_MAX);
        send_request(ole_pkg::OP_REMOVE, VAL_MIN);
        send_request(OP_RESERVED, -32'sd1);
        send_request(ole_pkg::OP_SORT, 32'sd0);
        send_request(ole_pkg::OP_SORT, VAL_MIN);
        send_request(ole_pkg::OP_SORT, VAL_MAX);
        send_request(ole_pkg::OP_SORT, 32'sd5);
        send_request(ole_pkg::OP_SORT, 32'sd5);
        send_request(ole_pkg::OP_FRONT, VAL_MAX);
        send_request(ole_pkg::OP_BACK, VAL_MIN);
        send_request(ole_pkg::OP_SEARCH, 32'sd5);
        send_request(ole_pkg::OP_REMOVE, VAL_MAX);
        send_request(ole_pkg::OP_REMOVE, VAL_MIN);

        // Fill to capacity, hit the full list with every insert kind, then search and remove the last entry
        while (sb.used < CAP) begin
            op = (sb.used % 2 == 0) ? ole_pkg::OP_BACK : ole_pkg::OP_FRONT;
            send_request(op, 32'(sb.used) - 32'sd3);
        end
        send_request(ole_pkg::OP_FRONT, 32'sd1);
        send_request(ole_pkg::OP_BACK, 32'sd1);
        send_request(ole_pkg::OP_SORT, 32'sd1);
        send_request(ole_pkg::OP_SEARCH, sb.slots[CAP-1]);
        send_request(ole_pkg::OP_REMOVE, sb.slots[CAP-1]);

        // Random traffic, alternating between growing and shrinking the list
        filling    = 1'b0;
        phase_left = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (phase_left == 0) begin
                filling    = !filling;
                phase_left = $urandom_range(25, 60);
            end
            phase_left--;
            pick = $urandom_range(0, 99);
            if (pick < 5) begin
                op = ole_pkg::OP_SEARCH + ole_pkg::OP_W'($urandom_range(1, 3));
            end else if (pick < (filling ? 70 : 20)) begin
                case ($urandom_range(0, 3))
                    0:       op = ole_pkg::OP_FRONT;
                    1:       op = ole_pkg::OP_BACK;
                    default: op = ole_pkg::OP_SORT;
                endcase
            end else if (pick < (filling ? 85 : 80)) begin
                op = ole_pkg::OP_REMOVE;
            end else begin
                op = ole_pkg::OP_SEARCH;
            end
            if ((op == ole_pkg::OP_REMOVE || op == ole_pkg::OP_SEARCH) && sb.used > 0
                    && $urandom_range(0, 3) != 0)
                val = sb.pick_entry();
            else
                val = pick_value();
            send_request(op, val);
        end
        req.valid <= 1'b0;

        // Drain outstanding responses, then let the block settle
        while (sb.owed.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.owed.size() != 0)
            sb.report($sformatf("%0d responses never arrived", sb.owed.size()));
        if (sb.fails == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Response side: check accepted responses and stall on a pattern of modes
    initial begin
        ole_pkg::t_result got;
        int               mode;
        int               mode_left;
        int               run_left;
        logic             run_level;
        logic             rdy;

        rsp.ready = 1'b0;
        mode      = 0;
        mode_left = 0;
        run_left  = 0;
        run_level = 1'b1;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && rsp.valid && rsp.ready) begin
                got.status      = rsp.status;
                got.position    = rsp.position;
                got.entry_count = rsp.entry_count;
                sb.check_response(got);
            end
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 120);
            end
            mode_left--;
            case (mode)
                0: rdy = 1'b1;
                1: rdy = $urandom_range(0, 1);
                2: rdy = ($urandom_range(0, 3) == 0);
                default: begin
                    // Alternate long stalls with short ready windows
                    if (run_left == 0) begin
                        run_level = !run_level;
                        run_left  = run_level ? $urandom_range(1, 6) : $urandom_range(1, 24);
                    end
                    run_left--;
                    rdy = run_level;
                end
            endcase
            rsp.ready <= rdy;
        end
    end

    // Watchdog: abort when neither side moves a request for too long
    initial begin
        int idle;
        idle = 0;
        @(posedge i_clk);
        while (!i_rst_n)
            @(posedge i_clk);
        while (idle < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
                idle = 0;
            else
                idle++;
        end
        $display("FAILURE");
        $finish;
    end

endmodule

// File: ordered_list_engine.f
design/ole_pkg.sv
design/ole_if.sv
design/ole_ctrl.sv
design/ole_dpath.sv
design/ordered_list_engine.sv
sim/ordered_list_engine_tb.sv
